[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of the deframer.
// Stand-alone header with no dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/xpd_pkg.sv]
// Package of the XOR-parity packet deframer: constants, codes and shared types.
// No dependencies; the frame tracker, drain unit, top level and testbench import it.
package xpd_pkg;

   localparam int unsigned MAX_PACKET_BYTES_DEF = 16;
   // Width of the packet count (counts up to 63 bytes)
   localparam int unsigned PKT_CNT_W = 6;

   localparam logic [7:0] TIMEOUT_RST = 8'd10;
   localparam logic [7:0] START_RST   = 8'hAB;
   localparam logic [7:0] STOP_RST    = 8'hCD;
   localparam logic [7:0] MIN_LEN     = 8'd3;

   // Register indexes of the configuration port
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_START   = 2'd1;
   localparam logic [1:0] REG_STOP    = 2'd2;

   // Frame phases
   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   typedef struct packed {
      logic                 go;
      logic [PKT_CNT_W-1:0] count;
   } xpd_drain_type;

endpackage

[rtl/xpd_req_if.sv]
// Input channel of the deframer: received byte or millisecond tick beats.
// Valid/ready handshake; no dependencies.
interface xpd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

[rtl/xpd_rsp_if.sv]
// Result channel of the deframer: command and data bytes of good packets.
// Valid/ready handshake; no dependencies.
interface xpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       is_command;
   logic       last;

   modport source (output valid, output packet_byte, output is_command, output last,
                   input ready);
   modport sink   (input valid, input packet_byte, input is_command, input last,
                   output ready);
endinterface

[rtl/xpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; width and depth set by parameters.
module xpd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/xpd_frame.sv]
// Frame tracker: hunt, length, body, parity and timeout; writes the packet store.
// Depends on xpd_pkg; starts the drain unit on a good stop byte.
module xpd_frame #(
   parameter int unsigned MAX_PACKET_BYTES = xpd_pkg::MAX_PACKET_BYTES_DEF,
   localparam int unsigned AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  logic                  action,
   input  logic [7:0]            data_byte,
   input  logic [7:0]            timeout_ticks,
   input  logic [7:0]            start_byte,
   input  logic [7:0]            stop_byte,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [7:0]            wr_data,
   output xpd_pkg::xpd_drain_type drain
);
   import xpd_pkg::*;

   localparam int unsigned CW      = $clog2(MAX_PACKET_BYTES + 3);
   localparam logic [7:0]  MAX_LEN = 8'(MAX_PACKET_BYTES + 2);

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    par_ff, par_in;
   logic          match_ff, match_in;
   logic [7:0]    idle_ff, idle_in;
   logic [7:0]    idle_inc;
   logic [CW-1:0] pkt;

   assign pkt      = len_ff - CW'(2);
   assign idle_inc = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      par_in      = par_ff;
      match_in    = match_ff;
      idle_in     = idle_ff;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[AW-1:0];
      wr_data     = data_byte;
      drain.go    = 1'b0;
      drain.count = PKT_CNT_W'(pkt);

      if (beat && action) begin
         if (phase_ff != PH_HUNT) begin
            idle_in = idle_inc;
            if (idle_inc >= timeout_ticks) begin
               phase_in = PH_HUNT;
               len_in   = '0;
               cnt_in   = '0;
               par_in   = '0;
               match_in = 1'b0;
               idle_in  = '0;
            end
         end
      end else if (beat) begin
         idle_in = '0;
         case (phase_ff)
            PH_HUNT: begin
               if (data_byte == start_byte) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (data_byte < MIN_LEN || data_byte > MAX_LEN) begin
                  phase_in = PH_HUNT;
                  len_in   = '0;
                  cnt_in   = '0;
                  par_in   = '0;
                  match_in = 1'b0;
               end else begin
                  phase_in = PH_BODY;
                  len_in   = CW'(data_byte);
                  par_in   = data_byte;
                  cnt_in   = '0;
                  match_in = 1'b0;
               end
            end
            PH_BODY: begin
               if (cnt_ff < pkt) begin
                  wr_en  = 1'b1;
                  par_in = par_ff ^ data_byte;
                  cnt_in = cnt_ff + CW'(1);
               end else if (cnt_ff == pkt) begin
                  match_in = (data_byte == par_ff);
                  cnt_in   = cnt_ff + CW'(1);
               end else begin
                  drain.go = (data_byte == stop_byte) && match_ff;
                  phase_in = PH_HUNT;
                  len_in   = '0;
                  cnt_in   = '0;
                  par_in   = '0;
                  match_in = 1'b0;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               len_in   = '0;
               cnt_in   = '0;
               par_in   = '0;
               match_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         cnt_ff   <= '0;
         par_ff   <= '0;
         match_ff <= 1'b0;
         idle_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         par_ff   <= par_in;
         match_ff <= match_in;
         idle_ff  <= idle_in;
      end
   end
endmodule

[rtl/xpd_drain.sv]
// Drain unit: reads the packet store into the result register, one entry a cycle while rsp does not stall.
// Depends on xpd_pkg and xpd_rsp_if; reports busy back to the input side.
module xpd_drain #(
   parameter int unsigned MAX_PACKET_BYTES = xpd_pkg::MAX_PACKET_BYTES_DEF,
   localparam int unsigned AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  xpd_pkg::xpd_drain_type drain,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [7:0]            rd_data,
   output logic                  busy,
   xpd_rsp_if.source             rsp
);
   import xpd_pkg::*;

   logic [PKT_CNT_W-1:0] rem_ff, rem_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic                 pend_cmd_ff, pend_cmd_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 cmd_ff, cmd_in;
   logic                 last_ff, last_in;
   logic                 load;

   // Move the fetched byte into the result register when it is free
   assign load  = pend_ff && (!valid_ff || rsp.ready);
   assign rd_en = (rem_ff != '0) && (!pend_ff || load);
   assign rd_addr = idx_ff;

   always_comb begin
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff && !load;
      pend_cmd_in  = pend_cmd_ff;
      pend_last_in = pend_last_ff;
      valid_in     = valid_ff && !rsp.ready;
      byte_in      = byte_ff;
      cmd_in       = cmd_ff;
      last_in      = last_ff;

      if (drain.go) begin
         rem_in = drain.count;
         idx_in = '0;
      end else if (rd_en) begin
         rem_in       = rem_ff - PKT_CNT_W'(1);
         idx_in       = idx_ff + AW'(1);
         pend_in      = 1'b1;
         pend_cmd_in  = (idx_ff == '0);
         pend_last_in = (rem_ff == PKT_CNT_W'(1));
      end

      if (load) begin
         valid_in = 1'b1;
         byte_in  = rd_data;
         cmd_in   = pend_cmd_ff;
         last_in  = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      idx_ff       <= idx_in;
      pend_cmd_ff  <= pend_cmd_in;
      pend_last_ff <= pend_last_in;
      byte_ff      <= byte_in;
      cmd_ff       <= cmd_in;
      last_ff      <= last_in;
   end

   assign busy            = (rem_ff != '0) || pend_ff || valid_ff;
   assign rsp.valid       = valid_ff;
   assign rsp.packet_byte = byte_ff;
   assign rsp.is_command  = cmd_ff;
   assign rsp.last        = last_ff;
endmodule

[rtl/xor_parity_packet_deframer.sv]
// Start/stop framed packet deframer with XOR parity. A req beat (a byte or
// a millisecond tick) is taken whenever no packet is draining. Bytes of the
// frame body land in a packet store RAM; after a good stop byte the command
// and data bytes are read back at one per cycle while rsp does not stall,
// through the RAM's single read port, and leave on rsp through the drain
// unit's result register. From the cycle after the stop beat until the last
// result beat is taken, req ready is low. Bad length, bad parity, bad stop
// byte and tick timeouts drop the frame without a result.
// Depends on xpd_pkg, xpd_req_if, xpd_rsp_if, xpd_ram, xpd_frame, xpd_drain.
module xor_parity_packet_deframer #(
   parameter int unsigned MAX_PACKET_BYTES = xpd_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   xpd_req_if.sink    req_if,
   xpd_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import xpd_pkg::*;

   localparam int unsigned AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

   // Configuration registers
   logic [7:0] timeout_ff, timeout_in;
   logic [7:0] start_ff, start_in;
   logic [7:0] stop_ff, stop_in;

   logic          beat;
   logic          busy;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   xpd_drain_type drain;

   // Decode the write; drop writes to indexes past the register list
   always_comb begin
      timeout_in = timeout_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TIMEOUT: timeout_in = csr_wdata;
            REG_START:   start_in   = csr_wdata;
            REG_STOP:    stop_in    = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         start_ff   <= START_RST;
         stop_ff    <= STOP_RST;
      end else begin
         timeout_ff <= timeout_in;
         start_ff   <= start_in;
         stop_ff    <= stop_in;
      end
   end

   // Hold the input while a packet drains, so the store is never written
   // and read in the same frame window
   assign req_if.ready = !busy;
   assign beat         = req_if.valid && !busy;

   xpd_frame #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .beat          (beat),
      .action        (req_if.action),
      .data_byte     (req_if.data_byte),
      .timeout_ticks (timeout_ff),
      .start_byte    (start_ff),
      .stop_byte     (stop_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .drain         (drain)
   );

   xpd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PACKET_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   xpd_drain #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_drain (
      .clock   (clock),
      .reset   (reset),
      .drain   (drain),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (busy),
      .rsp     (rsp_if)
   );
endmodule

[rtl/xpd_checker.sv]
// Port-level checker of the deframer, bound to the top level.
// Depends on assert_macros.svh and the top level's ports.
`include "assert_macros.svh"

module xpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_packet_byte,
   input logic       rsp_is_command,
   input logic       rsp_last
);
   // A result waiting means the input is held
   `ASSERT_SAME(a_rsp_holds_req, clock, reset, rsp_valid, !req_ready, "req ready while rsp pending")

   // Input frees up right after the final beat of a packet is taken
   `ASSERT_NEXT(a_last_frees_req, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready, "req not ready after last beat")

   // A tick never starts a packet burst
   `ASSERT_SAME(a_tick_no_rsp, clock, reset, req_valid && req_ready && req_action, ##2 !rsp_valid, "rsp after a tick")

   // A stalled result beat holds its payload
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_packet_byte) && $stable(rsp_is_command) && $stable(rsp_last), "rsp beat changed while stalled")
endmodule

bind xor_parity_packet_deframer xpd_checker u_xpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_action      (req_if.action),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_packet_byte (rsp_if.packet_byte),
   .rsp_is_command  (rsp_if.is_command),
   .rsp_last        (rsp_if.last)
);

[dv/xor_parity_packet_deframer_tb.sv]
// Self-checking testbench of the XOR-parity packet deframer: directed table, then random frames.
// Depends on xpd_pkg, xpd_req_if, xpd_rsp_if and the xor_parity_packet_deframer RTL.
module xor_parity_packet_deframer_tb;
   import xpd_pkg::*;

   localparam int          MAX_BYTES    = MAX_PACKET_BYTES_DEF;
   localparam int          DRAIN_CYCLES = 40;      // settle time after the last result beat
   localparam int          CYCLE_LIMIT  = 500000;
   localparam logic        ACT_BYTE     = 1'b0;
   localparam logic        ACT_TICK     = 1'b1;
   localparam logic [1:0]  REG_SPARE    = 2'd3;    // unmapped index, write must be ignored

   // How a directed row gets its expectation: from the predictor, or typed in.
   typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_kind_type;

   typedef struct packed {
      logic         action;
      logic [7:0]   data_byte;
      row_kind_type kind;
      logic [7:0]   cmd_byte;   // typed command byte of a one-byte packet (ROW_ONE)
   } stim_row_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       is_command;
      logic       last;
   } packet_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   xpd_req_if req_ch ();
   xpd_rsp_if rsp_ch ();

   xor_parity_packet_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Directed part, default registers: start 0xAB, stop 0xCD, timeout 10.
   stim_row_type directed_rows [0:25] = '{
      '{ACT_TICK, 8'h00, ROW_NONE, 8'h00},   // tick while hunting
      '{ACT_BYTE, 8'h00, ROW_NONE, 8'h00},   // stray byte while hunting
      '{ACT_BYTE, 8'hAB, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h02, ROW_NONE, 8'h00},   // length too small
      '{ACT_BYTE, 8'hAB, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h13, ROW_NONE, 8'h00},   // length too large
      '{ACT_BYTE, 8'hAB, ROW_NONE, 8'h00},   // shortest good frame, command 0xFF
      '{ACT_BYTE, 8'h03, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'hFF, ROW_NONE, 8'h00},
      '{ACT_TICK, 8'hFF, ROW_NONE, 8'h00},   // one tick of gap, well under timeout
      '{ACT_BYTE, 8'hFC, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'hCD, ROW_ONE,  8'hFF},
      '{ACT_BYTE, 8'hAB, ROW_NONE, 8'h00},   // bad parity
      '{ACT_BYTE, 8'h03, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h00, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h01, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'hCD, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'hAB, ROW_NONE, 8'h00},   // bad stop byte equal to the start byte
      '{ACT_BYTE, 8'h03, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h00, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h03, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'hAB, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h03, ROW_NONE, 8'h00},   // would frame only if the closer reopened
      '{ACT_BYTE, 8'h00, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'h03, ROW_NONE, 8'h00},
      '{ACT_BYTE, 8'hCD, ROW_NONE, 8'h00}
   };

   // Predictor state and register copies
   logic [7:0]   tmo_limit;
   logic [7:0]   sof_byte;
   logic [7:0]   eof_byte;
   logic [1:0]   frame_phase;
   logic [4:0]   len_field;
   logic [4:0]   body_seen;
   logic [7:0]   xor_acc;
   logic         xor_ok;
   logic [7:0]   quiet_ticks;
   logic [7:0]   payload_buf [MAX_BYTES];

   packet_beat_type burst_beats [$];      // results of the beat just predicted
   packet_beat_type expected_beats [$];   // results still owed by the DUT

   int unsigned  mismatches = 0;
   int unsigned  items_sent = 0;
   int unsigned  cycle_count = 0;
   int           hold_rsp_cycles = 0;  // long receiver hold-off, picked up by the drain process
   bit           no_gaps = 1'b0;       // both sides run without idle cycles

   initial begin
      forever #5 clock = ~clock;
   end

   // Abandon the frame and hunt for the start byte again.
   function automatic void rearm_hunt();
      frame_phase = PH_HUNT;
      len_field   = '0;
      body_seen   = '0;
      xor_acc     = '0;
      xor_ok      = 1'b0;
      quiet_ticks = '0;
   endfunction

   // Advance the deframer prediction by one accepted beat; fill burst_beats.
   function automatic void deframe_step(input logic act, input logic [7:0] b);
      logic [4:0] pkt_len;
      burst_beats.delete();
      if (act == ACT_TICK) begin
         if (frame_phase != PH_HUNT) begin
            if (quiet_ticks != 8'hFF) quiet_ticks++;
            if (quiet_ticks >= tmo_limit) rearm_hunt();
         end
         return;
      end
      quiet_ticks = '0;
      case (frame_phase)
         PH_HUNT: begin
            if (b == sof_byte) frame_phase = PH_LEN;
         end
         PH_LEN: begin
            if (b < MIN_LEN || int'(b) > MAX_BYTES + 2) begin
               rearm_hunt();
            end else begin
               len_field   = b[4:0];
               xor_acc     = b;
               body_seen   = '0;
               xor_ok      = 1'b0;
               frame_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            pkt_len = len_field - 5'd2;
            if (body_seen < pkt_len) begin
               if (body_seen < MAX_BYTES) payload_buf[body_seen] = b;
               xor_acc   = xor_acc ^ b;
               body_seen = body_seen + 5'd1;
            end else if (body_seen == pkt_len) begin
               xor_ok    = (b == xor_acc);
               body_seen = body_seen + 5'd1;
            end else begin
               if (b == eof_byte && xor_ok) begin
                  for (int k = 0; k < pkt_len && k < MAX_BYTES; k++) begin
                     burst_beats.push_back('{packet_byte: payload_buf[k],
                                             is_command:  (k == 0),
                                             last:        (k + 1 == pkt_len)});
                  end
               end
               rearm_hunt();
            end
         end
         default: rearm_hunt();
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // Offer one req beat after a random gap (none when no_gaps is set); hold valid high until it is taken.
   task automatic send_beat(input logic act, input logic [7:0] b, input row_kind_type kind,
                            input logic [7:0] cmd);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      deframe_step(act, b);
      case (kind)
         ROW_PREDICT: foreach (burst_beats[i]) expected_beats.push_back(burst_beats[i]);
         ROW_ONE:     expected_beats.push_back('{packet_byte: cmd, is_command: 1'b1, last: 1'b1});
         default:     ;   // typed as no result: drop the prediction
      endcase
   endtask

   task automatic offer(input logic act, input logic [7:0] b);
      send_beat(act, b, ROW_PREDICT, 8'h00);
   endtask

   // Feed ticks until the predicted phase is back to hunting.
   task automatic flush_to_hunt();
      while (frame_phase != PH_HUNT) offer(ACT_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Feed zero bytes until the open frame closes; MAX_BYTES + 2 bytes at most.
   task automatic close_frame();
      while (frame_phase != PH_HUNT) offer(ACT_BYTE, 8'h00);
   endtask

   // Drop valid and wait until every owed result beat has been taken.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_TIMEOUT: tmo_limit = val;
         REG_START:   sof_byte  = val;
         REG_STOP:    eof_byte  = val;
         default:     ;
      endcase
   endtask

   // Bring the block to idle, then write all three registers (and the spare index if asked).
   task automatic reconfigure(input logic [7:0] tmo, input logic [7:0] sof,
                              input logic [7:0] eof, input bit touch_spare);
      close_frame();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_START, sof);
      if (touch_spare) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
      write_reg(REG_STOP, eof);
      csr_we <= 1'b0;
   endtask

   // One frame with random body; parity and stop are mostly right. A zero length draws one.
   task automatic send_frame(input int forced_len);
      int         len;
      int         pick;
      int         n_ticks;
      logic [7:0] par;
      logic [7:0] body;
      len = forced_len;
      if (len == 0) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)      len = $urandom_range(0, 2);
         else if (pick == 1) len = $urandom_range(19, 255);
         else if (pick < 4)  len = MAX_BYTES + 2;
         else                len = $urandom_range(3, 8);
      end
      offer(ACT_BYTE, sof_byte);
      offer(ACT_BYTE, 8'(len));
      if (len < 3 || len > MAX_BYTES + 2) return;
      par = 8'(len);
      for (int i = 0; i < len - 2; i++) begin
         body = 8'($urandom_range(0, 255));
         // short tick gaps inside the frame, always under the timeout
         if (tmo_limit > 1 && $urandom_range(0, 7) == 0) begin
            n_ticks = (tmo_limit > 4) ? $urandom_range(1, 3) : $urandom_range(1, tmo_limit - 1);
            repeat (n_ticks) offer(ACT_TICK, 8'($urandom_range(0, 255)));
         end
         offer(ACT_BYTE, body);
         par = par ^ body;
      end
      offer(ACT_BYTE, ($urandom_range(0, 9) == 0) ? par ^ 8'($urandom_range(1, 255)) : par);
      offer(ACT_BYTE, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : eof_byte);
   endtask

   // Random mix: mostly well-formed frames, some noise, truncated frames and tick aborts.
   task automatic run_random(input int n_items);
      int unsigned target;
      int          pick;
      int          n_body;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(0);
         end else if (pick < 82) begin
            offer(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else if (pick < 90 && tmo_limit <= 20) begin
            // open a frame and let it time out
            offer(ACT_BYTE, sof_byte);
            offer(ACT_BYTE, 8'($urandom_range(3, MAX_BYTES + 2)));
            repeat ($urandom_range(0, 3)) offer(ACT_BYTE, 8'($urandom_range(0, 255)));
            flush_to_hunt();
         end else begin
            // truncated frame, cut short by the next one
            offer(ACT_BYTE, sof_byte);
            offer(ACT_BYTE, 8'($urandom_range(3, MAX_BYTES + 2)));
            n_body = $urandom_range(0, 4);
            repeat (n_body) offer(ACT_BYTE, 8'($urandom_range(0, 255)));
            send_frame(0);
         end
      end
   endtask

   // Result side: random ready gaps per beat, plus one long hold-off on request.
   initial begin : rsp_drain
      int gap;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_cycles > 0) begin
            gap = hold_rsp_cycles;
            hold_rsp_cycles = 0;
         end else begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Compare every taken result beat with the oldest owed one.
   always @(posedge clock) begin
      packet_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unowed result beat, packet_byte", rsp_ch.packet_byte, 8'h00);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_ch.packet_byte !== want.packet_byte)
               report_mismatch("packet_byte", rsp_ch.packet_byte, want.packet_byte);
            if (rsp_ch.is_command !== want.is_command)
               report_mismatch("is_command", 8'(rsp_ch.is_command), 8'(want.is_command));
            if (rsp_ch.last !== want.last)
               report_mismatch("last", 8'(rsp_ch.last), 8'(want.last));
         end
      end
   end

   // Watchdog: end a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_BYTE;
      req_ch.data_byte = 8'h00;
      csr_we           = 1'b0;
      csr_index        = REG_TIMEOUT;
      csr_wdata        = 8'h00;
      tmo_limit        = TIMEOUT_RST;
      sof_byte         = START_RST;
      eof_byte         = STOP_RST;
      rearm_hunt();

      // hold reset at the start, then release it once for good
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table under the reset register values
      foreach (directed_rows[i])
         send_beat(directed_rows[i].action, directed_rows[i].data_byte,
                   directed_rows[i].kind, directed_rows[i].cmd_byte);
      send_frame(MAX_BYTES + 2);
      run_random(60);

      // shortest timeout: any tick inside a frame aborts it
      reconfigure(8'd1, 8'h00, 8'hFF, 1'b0);
      send_frame(MAX_BYTES + 2);
      run_random(60);

      // longest timeout, no idling on either side
      reconfigure(8'd255, 8'hFF, 8'h00, 1'b0);
      no_gaps = 1'b1;
      send_frame(MAX_BYTES + 2);
      run_random(60);
      no_gaps = 1'b0;

      // random registers, spare index written; stall the receiver so the input backs up
      reconfigure(8'($urandom_range(2, 20)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b1);
      hold_rsp_cycles = 400;
      run_random(30);
      // pause the sender until every owed beat has come out
      wait_drained();
      run_random(30);

      // start and stop share one value
      sof_byte = 8'($urandom_range(0, 255));
      reconfigure(8'($urandom_range(3, 12)), sof_byte, sof_byte, 1'b0);
      run_random(60);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
